// ===== rtl/psfd_pkg.sv =====
// shared types and constants for the per-source flood detector
`timescale 1ns / 1ps
package psfd_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int UsedW = $clog2(TableDepth + 1);
  localparam logic [1:0] StatusExisting = 2'd0;
  localparam logic [1:0] StatusAdded = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;
  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [0:0] RegWindow = 1'b1;

  // one packet waiting between front and back
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] now;
  } pkt_t;
endpackage

// ===== rtl/psfd_front.sv =====
// input queue: accepts packets and holds them for the table engine
`timescale 1ns / 1ps
module psfd_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] source_address,
  input  logic [31:0] now_seconds,
  output logic q_valid,
  input  logic q_take,
  output psfd_pkg::pkt_t q_pkt
);
  // two-entry queue
  psfd_pkg::pkt_t slot0, slot1;
  logic [1:0] fill;
  logic push, pop;

  assign in_stall = fill[1];
  assign push = in_valid & ~fill[1];
  assign pop = q_take & (fill != 2'd0);
  assign q_valid = fill != 2'd0;
  assign q_pkt = slot0;

  // queue storage
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && fill == 2'd1) slot0 <= {source_address, now_seconds};
      else slot0 <= slot1;
    end else if (push) begin
      if (fill == 2'd0) slot0 <= {source_address, now_seconds};
      else slot1 <= {source_address, now_seconds};
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) fill <= 2'd0;
    else fill <= fill + {1'b0, push} - {1'b0, pop};
  end
endmodule

// ===== rtl/psfd_back.sv =====
// table engine: linear search over the source table, window update, result register
`timescale 1ns / 1ps
module psfd_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  psfd_pkg::pkt_t q_pkt,
  input  logic [15:0] threshold,
  input  logic [15:0] window,
  output logic out_valid,
  input  logic out_stall,
  output logic alert,
  output logic [15:0] packet_count,
  output logic [1:0] lookup_status
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SCmp = 3'd2;
  localparam logic [2:0] SUpd = 3'd3;
  localparam logic [2:0] SOut = 3'd4;

  // entry memory: {alerted, count, start, address}
  logic [80:0] mem [psfd_pkg::TableDepth];
  logic [80:0] rd;
  logic [80:0] wr;
  logic we;
  logic [psfd_pkg::IdxW-1:0] ra, wa;

  logic [2:0] state;
  logic [psfd_pkg::UsedW-1:0] used, scan;
  psfd_pkg::pkt_t pkt;
  logic hit;
  logic full_drop;
  logic out_free;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wr;
    rd <= mem[ra];
  end

  assign ra = scan[psfd_pkg::IdxW-1:0];
  assign q_take = state == SIdle;

  // entry update
  logic [31:0] st, elapsed;
  logic [15:0] cnt, cnt_new;
  logic al, al_new, restart;
  always_comb begin
    if (hit) begin
      st = rd[63:32];
      cnt = rd[79:64];
      al = rd[80];
    end else begin
      st = pkt.now;
      cnt = 16'd0;
      al = 1'b0;
    end
    elapsed = pkt.now - st;
    restart = elapsed > {16'd0, window};
    cnt_new = restart ? 16'd1 : (cnt == 16'hFFFF ? cnt : cnt + 16'd1);
    al_new = restart ? 1'b0 : al;
    wr = {1'b1, cnt_new, restart ? pkt.now : st, pkt.addr};
    if (cnt_new >= threshold && !al_new) wr[80] = 1'b1;
    else wr[80] = al_new;
  end

  // write once, when the result register takes the packet, and never for a dropped packet
  assign full_drop = !hit && used == psfd_pkg::UsedW'(psfd_pkg::TableDepth);
  assign out_free = !out_valid || !out_stall;
  assign we = state == SUpd && out_free && !full_drop;
  assign wa = hit ? scan[psfd_pkg::IdxW-1:0] : used[psfd_pkg::IdxW-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        SIdle: begin
          if (q_valid) begin
            pkt <= q_pkt;
            scan <= '0;
            hit <= 1'b0;
            state <= SRead;
          end
        end
        SRead: begin
          if (scan == used) state <= SUpd;
          else state <= SCmp;
        end
        SCmp: begin
          if (rd[31:0] == pkt.addr) begin
            hit <= 1'b1;
            state <= SUpd;
          end else begin
            scan <= scan + 1'b1;
            state <= SRead;
          end
        end
        SUpd: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (full_drop) begin
              alert <= 1'b0;
              packet_count <= 16'd0;
              lookup_status <= psfd_pkg::StatusFull;
            end else begin
              alert <= wr[80] & ~al_new;
              packet_count <= cnt_new;
              lookup_status <= hit ? psfd_pkg::StatusExisting : psfd_pkg::StatusAdded;
              if (!hit) used <= used + 1'b1;
            end
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
      if (out_valid && !out_stall && !(state == SUpd)) out_valid <= 1'b0;
    end
  end
endmodule

// ===== rtl/per_source_flood_detector.sv =====
// top level of the per-source flood detector
// each packet is taken in the idle state, then passes a read and a compare state for each
//   entry scanned, to a hit or to the last entry in use, then waits in the update state until
//   the result register is free; the engine takes a new packet only after the last is registered,
//   and the single read port of the entry memory lets it compare one entry at a time
// a two-entry input queue accepts packets while the engine searches; a stalled result holds it
// reset: synchronous, clears table fill count and queue; registers go to 20 and 5
`timescale 1ns / 1ps
module per_source_flood_detector (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] source_address,
  input  logic [31:0] now_seconds,
  output logic out_valid,
  input  logic out_stall,
  output logic alert,
  output logic [15:0] packet_count,
  output logic [1:0] lookup_status,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic q_valid, q_take;
  psfd_pkg::pkt_t q_pkt;
  logic [15:0] threshold, window;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd20;
      window <= 16'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        psfd_pkg::RegThreshold: threshold <= cfg_data;
        psfd_pkg::RegWindow: window <= cfg_data;
        default: ;
      endcase
    end
  end

  psfd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .source_address, .now_seconds,
    .q_valid, .q_take, .q_pkt
  );

  psfd_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_pkt, .threshold, .window,
    .out_valid, .out_stall, .alert, .packet_count, .lookup_status
  );
endmodule

// ===== rtl/psfd_checker.sv =====
// port-level checks for the per-source flood detector
`timescale 1ns / 1ps
module psfd_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic alert,
  input logic [15:0] packet_count,
  input logic [1:0] lookup_status
);
  // a dropped packet reports zero count and no alert
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && lookup_status == psfd_pkg::StatusFull |-> !alert && packet_count == 16'd0)
    else $error("dropped packet with count or alert");
  // a kept packet always has a nonzero count
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && lookup_status != psfd_pkg::StatusFull |-> packet_count != 16'd0)
    else $error("zero count on kept packet");
  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lookup_status != 2'd3)
    else $error("bad status");
  // stalled result holds valid, count and alert
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packet_count) && $stable(alert))
    else $error("stalled result changed");
endmodule

bind per_source_flood_detector psfd_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .alert, .packet_count, .lookup_status
);
